/* hw/rtl/pftm_pkg.sv */
package pftm_pkg;

    localparam logic [1:0] ACT_CLEAR    = 2'd0;
    localparam logic [1:0] ACT_APPEND   = 2'd1;
    localparam logic [1:0] ACT_CLASSIFY = 2'd2;

    localparam logic [15:0] ETH_ARP  = 16'h0806;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86dd;

    localparam logic [7:0] NP_ICMP4 = 8'd1;
    localparam logic [7:0] NP_ICMP6 = 8'd58;
    localparam logic [7:0] NP_TCP   = 8'd6;
    localparam logic [7:0] NP_UDP   = 8'd17;

    localparam logic [2:0] PR_ANY  = 3'd0;
    localparam logic [2:0] PR_ARP  = 3'd1;
    localparam logic [2:0] PR_ICMP = 3'd2;
    localparam logic [2:0] PR_TCP  = 3'd3;
    localparam logic [2:0] PR_UDP  = 3'd4;

    localparam logic [1:0] VER_ANY = 2'd0;
    localparam logic [1:0] VER_V4  = 2'd1;
    localparam logic [1:0] VER_V6  = 2'd2;

    localparam logic [2:0] CLS_OTHER = 3'd0;
    localparam logic [2:0] CLS_ARP   = 3'd1;
    localparam logic [2:0] CLS_ICMP4 = 3'd2;
    localparam logic [2:0] CLS_TCP4  = 3'd3;
    localparam logic [2:0] CLS_UDP4  = 3'd4;
    localparam logic [2:0] CLS_ICMP6 = 3'd5;
    localparam logic [2:0] CLS_TCP6  = 3'd6;
    localparam logic [2:0] CLS_UDP6  = 3'd7;

    localparam int HIT_W = 4;

    typedef struct packed {
        logic [1:0]  version;
        logic [2:0]  protocol;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } rule_t;

    typedef struct packed {
        logic             valid;
        logic [2:0]       cls;
        logic [63:0]      src_hi;
        logic [63:0]      src_lo;
        logic [63:0]      dst_hi;
        logic [63:0]      dst_lo;
        logic [15:0]      src_port;
        logic [15:0]      dst_port;
        logic             found;
        logic [HIT_W-1:0] hit;
    } token_t;

    function automatic logic [2:0] classify(input logic [15:0] eth, input logic [7:0] np);
        logic [2:0] cls;
        cls = CLS_OTHER;
        if (eth == ETH_ARP) begin
            cls = CLS_ARP;
        end else if (eth == ETH_IPV4) begin
            if (np == NP_ICMP4) cls = CLS_ICMP4;
            else if (np == NP_TCP) cls = CLS_TCP4;
            else if (np == NP_UDP) cls = CLS_UDP4;
        end else if (eth == ETH_IPV6) begin
            if (np == NP_ICMP6) cls = CLS_ICMP6;
            else if (np == NP_TCP) cls = CLS_TCP6;
            else if (np == NP_UDP) cls = CLS_UDP6;
        end
        return cls;
    endfunction

    function automatic logic [1:0] cls_version(input logic [2:0] cls);
        logic [1:0] v;
        case (cls)
            CLS_ICMP4, CLS_TCP4, CLS_UDP4: v = VER_V4;
            CLS_ICMP6, CLS_TCP6, CLS_UDP6: v = VER_V6;
            default:                       v = VER_ANY;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] cls_protocol(input logic [2:0] cls);
        logic [2:0] p;
        case (cls)
            CLS_ARP:              p = PR_ARP;
            CLS_ICMP4, CLS_ICMP6: p = PR_ICMP;
            CLS_TCP4, CLS_TCP6:   p = PR_TCP;
            CLS_UDP4, CLS_UDP6:   p = PR_UDP;
            default:              p = PR_ANY;
        endcase
        return p;
    endfunction

    function automatic logic rule_match(input rule_t r, input token_t t);
        logic [2:0] pp;
        logic       ver_ok;
        logic       proto_ok;
        logic       src_ok;
        logic       dst_ok;
        logic       port_ok;
        pp       = cls_protocol(t.cls);
        ver_ok   = (t.cls == CLS_ARP) || (r.version == VER_ANY)
                   || (r.version == cls_version(t.cls));
        proto_ok = (r.protocol == PR_ANY) || (r.protocol == pp);
        src_ok   = ({r.src_hi, r.src_lo} == 128'd0)
                   || ({r.src_hi, r.src_lo} == {t.src_hi, t.src_lo});
        dst_ok   = ({r.dst_hi, r.dst_lo} == 128'd0)
                   || ({r.dst_hi, r.dst_lo} == {t.dst_hi, t.dst_lo});
        port_ok  = 1'b1;
        if (pp == PR_TCP || pp == PR_UDP) begin
            port_ok = ((r.src_port == 16'd0) || (r.src_port == t.src_port))
                      && ((r.dst_port == 16'd0) || (r.dst_port == t.dst_port));
        end
        return (t.cls != CLS_OTHER) && ver_ok && proto_ok && src_ok && dst_ok && port_ok;
    endfunction

endpackage

/* hw/rtl/pftm_in_if.sv */
interface pftm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] ethertype;
    logic [7:0]  next_proto;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [1:0]  rule_version;
    logic [2:0]  rule_protocol;

    modport source (
        output valid, action, ethertype, next_proto, src_addr_hi, src_addr_lo,
               dst_addr_hi, dst_addr_lo, src_port, dst_port, rule_version, rule_protocol,
        input  ready
    );

    modport sink (
        input  valid, action, ethertype, next_proto, src_addr_hi, src_addr_lo,
               dst_addr_hi, dst_addr_lo, src_port, dst_port, rule_version, rule_protocol,
        output ready
    );
endinterface

/* hw/rtl/pftm_out_if.sv */
interface pftm_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] packet_class;
    logic       matched;
    logic [3:0] rule_hit;

    modport source (
        output valid, packet_class, matched, rule_hit,
        input  ready
    );

    modport sink (
        input  valid, packet_class, matched, rule_hit,
        output ready
    );
endinterface

/* hw/rtl/pftm_cell.sv */
module pftm_cell #(
    parameter int IDX = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             active,
    input  logic             wr_en,
    input  pftm_pkg::rule_t  wr_rule,
    input  pftm_pkg::token_t tok_in,
    output pftm_pkg::token_t tok_out
);

    pftm_pkg::rule_t  rule_reg;
    pftm_pkg::token_t tok_reg;
    pftm_pkg::token_t tok_next;
    logic             vld_reg;
    logic             vld_next;
    logic             hit_now;

    always_comb
    begin
        hit_now  = tok_in.valid && active && !tok_in.found
                   && pftm_pkg::rule_match(rule_reg, tok_in);
        tok_next = tok_in;
        vld_next = tok_in.valid;
        if (hit_now)
        begin
            tok_next.found = 1'b1;
            tok_next.hit   = pftm_pkg::HIT_W'(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tok_reg <= tok_next;
        end
        if (wr_en)
        begin
            rule_reg <= wr_rule;
        end
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = vld_reg;
    end

endmodule

/* hw/rtl/packet_five_tuple_rule_match_top.sv */
// Five-tuple first-match classifier built as a chain of MAX_RULES rule cells, each
// holding one rule. A clear or append transfer updates the rule table on acceptance.
// A classify transfer walks the chain one cell per cycle unless the response side
// stalls it; the chain carries one packet at a time, so the next transfer is taken
// once that packet has left the last cell and its result is registered for output.
module packet_five_tuple_rule_match_top #(
    parameter int MAX_RULES = 16
) (
    input logic        clk,
    input logic        rst_n,
    pftm_in_if.sink    req,
    pftm_out_if.source rsp
);

    localparam int CW = $clog2(MAX_RULES + 1);

    pftm_pkg::token_t      tok [MAX_RULES+1];
    pftm_pkg::rule_t       wr_rule;
    logic [MAX_RULES-1:0]  wr_en;
    logic [MAX_RULES-1:0]  active;
    logic [MAX_RULES-1:0]  vld;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  busy;
    logic                  adv;
    logic                  acc;
    logic                  append;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [2:0]            cls_reg;
    logic                  matched_reg;
    logic [3:0]            hit_reg;

    assign busy      = |vld;
    assign req.ready = !busy;
    assign acc       = req.valid && req.ready;
    assign adv       = !tok[MAX_RULES].valid || !out_valid_reg || rsp.ready;
    assign append    = acc && (req.action == pftm_pkg::ACT_APPEND)
                       && (count_reg < CW'(MAX_RULES));

    always_comb
    begin
        wr_rule.version  = req.rule_version;
        wr_rule.protocol = req.rule_protocol;
        wr_rule.src_hi   = req.src_addr_hi;
        wr_rule.src_lo   = req.src_addr_lo;
        wr_rule.dst_hi   = req.dst_addr_hi;
        wr_rule.dst_lo   = req.dst_addr_lo;
        wr_rule.src_port = req.src_port;
        wr_rule.dst_port = req.dst_port;

        tok[0].valid    = acc && (req.action == pftm_pkg::ACT_CLASSIFY);
        tok[0].cls      = pftm_pkg::classify(req.ethertype, req.next_proto);
        tok[0].src_hi   = req.src_addr_hi;
        tok[0].src_lo   = req.src_addr_lo;
        tok[0].dst_hi   = req.dst_addr_hi;
        tok[0].dst_lo   = req.dst_addr_lo;
        tok[0].src_port = req.src_port;
        tok[0].dst_port = req.dst_port;
        tok[0].found    = 1'b0;
        tok[0].hit      = '0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_RULES; gi++)
        begin : g_cell
            assign wr_en[gi]  = append && (count_reg == CW'(gi));
            assign active[gi] = CW'(gi) < count_reg;
            assign vld[gi]    = tok[gi+1].valid;

            pftm_cell #(
                .IDX (gi)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .adv     (adv),
                .active  (active[gi]),
                .wr_en   (wr_en[gi]),
                .wr_rule (wr_rule),
                .tok_in  (tok[gi]),
                .tok_out (tok[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (acc && (req.action == pftm_pkg::ACT_CLEAR))
        begin
            count_next = '0;
        end
        else if (append)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (tok[MAX_RULES].valid && adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok[MAX_RULES].valid && adv)
        begin
            cls_reg     <= tok[MAX_RULES].cls;
            matched_reg <= tok[MAX_RULES].found;
            hit_reg     <= tok[MAX_RULES].hit;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.packet_class = cls_reg;
    assign rsp.matched      = matched_reg;
    assign rsp.rule_hit     = hit_reg;

    a_one_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(vld) <= 1)
        else $error("more than one packet in the rule chain");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RULES))
        else $error("rule count exceeds capacity");

    a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.matched) |-> (rsp.rule_hit == 4'd0))
        else $error("rule index set without a match");

    a_other_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.packet_class == pftm_pkg::CLS_OTHER)) |-> !rsp.matched)
        else $error("unclassified packet reported a match");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        append |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("append did not advance the rule count");

endmodule

/* dv/tb_packet_five_tuple_rule_match_top.sv */
module tb_packet_five_tuple_rule_match_top;

    localparam int MAX_RULES = 16;
    localparam int AW        = $clog2(MAX_RULES);

    localparam logic [1:0] ACT_IGNORED = 2'd3;
    localparam logic [1:0] VER_RSVD    = 2'd3;
    localparam logic [2:0] PR_RSVD     = 3'd7;

    localparam int unsigned ITEMS_PER_PHASE = 140;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned DRAIN_CYCLES    = 2 * (MAX_RULES + 1) + 8;

    localparam logic [63:0] ONES   = '1;
    localparam logic [63:0] V4_SRC = 64'h0000_0000_c0a8_0a01;
    localparam logic [63:0] V4_DST = 64'h0000_0000_0a00_0002;
    localparam logic [63:0] V6_HI  = 64'h2001_0db8_0000_0001;
    localparam logic [63:0] V6_LO  = 64'h0000_0000_0000_00ff;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] ethertype;
        logic [7:0]  next_proto;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [1:0]  rule_version;
        logic [2:0]  rule_protocol;
    } hdr_t;

    typedef struct packed {
        logic [2:0]                 cls;
        logic                       matched;
        logic [pftm_pkg::HIT_W-1:0] hit;
    } verdict_t;

    typedef struct packed {
        logic [1:0]   version;
        logic [2:0]   protocol;
        logic [127:0] src;
        logic [127:0] dst;
        logic [15:0]  sport;
        logic [15:0]  dport;
    } acl_entry_t;

    typedef struct packed {
        logic [7:0] reps;
        hdr_t       item;
        logic       typed;
        verdict_t   want;
    } drow_t;

    typedef enum int unsigned {
        PH_STEADY,
        PH_SRC_IDLE,
        PH_SNK_STALL,
        PH_BOTH_IDLE,
        PH_BACKPRESSURE
    } flow_phase_t;

    localparam verdict_t NO_VERDICT = '0;

    logic clk;
    logic rst_n;

    pftm_in_if  req_if ();
    pftm_out_if rsp_if ();

    packet_five_tuple_rule_match_top #(
        .MAX_RULES(MAX_RULES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_if),
        .rsp(rsp_if)
    );

    acl_entry_t  acl_table [MAX_RULES];
    int unsigned acl_count;
    verdict_t    pending_verdicts [$];
    drow_t       steps [$];

    flow_phase_t flow;
    int unsigned idle_pct;
    int unsigned stall_pct;

    int unsigned n_errors;
    int unsigned n_results;
    int unsigned n_transfers;
    int unsigned n_classified;
    int unsigned n_matched;
    int unsigned n_top_hit;
    int unsigned n_stored;
    int unsigned n_dropped;
    int unsigned n_clears;
    int unsigned n_ignored;

    function automatic hdr_t hdr(input logic [1:0] action, input logic [15:0] eth,
                                 input logic [7:0] np, input logic [63:0] sh,
                                 input logic [63:0] sl, input logic [63:0] dh,
                                 input logic [63:0] dl, input logic [15:0] sp,
                                 input logic [15:0] dp, input logic [1:0] ver,
                                 input logic [2:0] pr);
        hdr_t h;
        h = '{action, eth, np, sh, sl, dh, dl, sp, dp, ver, pr};
        return h;
    endfunction

    function automatic drow_t row(input logic [7:0] reps, input hdr_t h, input logic typed,
                                  input verdict_t want);
        drow_t r;
        r = '{reps, h, typed, want};
        return r;
    endfunction

    function automatic logic [2:0] sort_header(input logic [15:0] eth, input logic [7:0] np);
        logic [2:0] base;
        case (eth)
            pftm_pkg::ETH_ARP:  return pftm_pkg::CLS_ARP;
            pftm_pkg::ETH_IPV4: base = pftm_pkg::CLS_ICMP4;
            pftm_pkg::ETH_IPV6: base = pftm_pkg::CLS_ICMP6;
            default:            return pftm_pkg::CLS_OTHER;
        endcase
        if (np == ((eth == pftm_pkg::ETH_IPV4) ? pftm_pkg::NP_ICMP4 : pftm_pkg::NP_ICMP6))
            return base;
        if (np == pftm_pkg::NP_TCP) return base + 3'd1;
        if (np == pftm_pkg::NP_UDP) return base + 3'd2;
        return pftm_pkg::CLS_OTHER;
    endfunction

    function automatic logic [1:0] family_of(input logic [2:0] c);
        if (c >= pftm_pkg::CLS_ICMP6) return pftm_pkg::VER_V6;
        if (c >= pftm_pkg::CLS_ICMP4) return pftm_pkg::VER_V4;
        return pftm_pkg::VER_ANY;
    endfunction

    function automatic logic [2:0] l4_of(input logic [2:0] c);
        if (c == pftm_pkg::CLS_ARP) return pftm_pkg::PR_ARP;
        if (c == pftm_pkg::CLS_OTHER) return pftm_pkg::PR_ANY;
        return pftm_pkg::PR_ICMP + 3'((c - pftm_pkg::CLS_ICMP4) % 3);
    endfunction

    function automatic bit entry_hits(input acl_entry_t e, input logic [2:0] c, input hdr_t h);
        logic [2:0] l4;
        l4 = l4_of(c);
        if (c != pftm_pkg::CLS_ARP && e.version != pftm_pkg::VER_ANY
            && e.version != family_of(c)) return 1'b0;
        if (e.protocol != pftm_pkg::PR_ANY && e.protocol != l4) return 1'b0;
        if (e.src != '0 && e.src != {h.src_hi, h.src_lo}) return 1'b0;
        if (e.dst != '0 && e.dst != {h.dst_hi, h.dst_lo}) return 1'b0;
        if (l4 == pftm_pkg::PR_TCP || l4 == pftm_pkg::PR_UDP)
        begin
            if (e.sport != '0 && e.sport != h.src_port) return 1'b0;
            if (e.dport != '0 && e.dport != h.dst_port) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic verdict_t lookup_verdict(input hdr_t h);
        verdict_t v;
        v = NO_VERDICT;
        v.cls = sort_header(h.ethertype, h.next_proto);
        if (v.cls == pftm_pkg::CLS_OTHER) return v;
        for (int unsigned i = 0; i < acl_count; i++)
        begin
            if (!v.matched && entry_hits(acl_table[i[AW-1:0]], v.cls, h))
            begin
                v.matched = 1'b1;
                v.hit     = pftm_pkg::HIT_W'(i);
            end
        end
        return v;
    endfunction

    function automatic void account(input hdr_t h, input logic typed, input verdict_t want);
        verdict_t v;
        n_transfers++;
        case (h.action)
            pftm_pkg::ACT_CLEAR:
            begin
                acl_count = 0;
                n_clears++;
            end
            pftm_pkg::ACT_APPEND:
            begin
                if (acl_count < MAX_RULES)
                begin
                    acl_table[acl_count[AW-1:0]] = '{h.rule_version, h.rule_protocol,
                                                     {h.src_hi, h.src_lo},
                                                     {h.dst_hi, h.dst_lo},
                                                     h.src_port, h.dst_port};
                    acl_count++;
                    n_stored++;
                end
                else
                begin
                    n_dropped++;
                end
            end
            pftm_pkg::ACT_CLASSIFY:
            begin
                v = typed ? want : lookup_verdict(h);
                pending_verdicts.push_back(v);
                n_classified++;
                if (v.matched) n_matched++;
                if (v.matched && v.hit == pftm_pkg::HIT_W'(MAX_RULES - 1)) n_top_hit++;
            end
            default: n_ignored++;
        endcase
    endfunction

    function automatic hdr_t random_header();
        hdr_t        h;
        acl_entry_t  e;
        int unsigned roll;
        h.action        = pftm_pkg::ACT_CLASSIFY;
        h.ethertype     = 16'($urandom);
        h.next_proto    = 8'($urandom);
        h.src_hi        = {$urandom, $urandom};
        h.src_lo        = {$urandom, $urandom};
        h.dst_hi        = {$urandom, $urandom};
        h.dst_lo        = {$urandom, $urandom};
        h.src_port      = 16'($urandom);
        h.dst_port      = 16'($urandom);
        h.rule_version  = 2'($urandom);
        h.rule_protocol = 3'($urandom);
        roll = $urandom_range(99);
        if (roll < 3)
        begin
            h.action = pftm_pkg::ACT_CLEAR;
        end
        else if (roll < 5)
        begin
            h.action = ACT_IGNORED;
        end
        else if (roll < 30)
        begin
            h.action = pftm_pkg::ACT_APPEND;
            if ($urandom_range(9) < 5) h.rule_version = pftm_pkg::VER_ANY;
            roll = $urandom_range(99);
            if (roll < 40) h.rule_protocol = pftm_pkg::PR_ANY;
            else if (roll < 92) h.rule_protocol = 3'($urandom_range(1, 4));
            else h.rule_protocol = 3'($urandom_range(5, 7));
            if ($urandom_range(1) == 0) {h.src_hi, h.src_lo} = '0;
            if ($urandom_range(1) == 0) {h.dst_hi, h.dst_lo} = '0;
            if ($urandom_range(2) == 0) h.src_port = '0;
            else if ($urandom_range(1) == 0) h.src_port = 16'($urandom_range(1, 4));
            if ($urandom_range(2) == 0) h.dst_port = '0;
            else if ($urandom_range(1) == 0) h.dst_port = 16'($urandom_range(1, 4));
        end
        else
        begin
            if ($urandom_range(9) != 0)
            begin
                case (3'($urandom_range(1, 7)))
                    pftm_pkg::CLS_ARP:
                    begin
                        h.ethertype = pftm_pkg::ETH_ARP;
                    end
                    pftm_pkg::CLS_ICMP4:
                    begin
                        h.ethertype  = pftm_pkg::ETH_IPV4;
                        h.next_proto = pftm_pkg::NP_ICMP4;
                    end
                    pftm_pkg::CLS_TCP4:
                    begin
                        h.ethertype  = pftm_pkg::ETH_IPV4;
                        h.next_proto = pftm_pkg::NP_TCP;
                    end
                    pftm_pkg::CLS_UDP4:
                    begin
                        h.ethertype  = pftm_pkg::ETH_IPV4;
                        h.next_proto = pftm_pkg::NP_UDP;
                    end
                    pftm_pkg::CLS_ICMP6:
                    begin
                        h.ethertype  = pftm_pkg::ETH_IPV6;
                        h.next_proto = pftm_pkg::NP_ICMP6;
                    end
                    pftm_pkg::CLS_TCP6:
                    begin
                        h.ethertype  = pftm_pkg::ETH_IPV6;
                        h.next_proto = pftm_pkg::NP_TCP;
                    end
                    default:
                    begin
                        h.ethertype  = pftm_pkg::ETH_IPV6;
                        h.next_proto = pftm_pkg::NP_UDP;
                    end
                endcase
            end
            else if ($urandom_range(1) == 0)
            begin
                h.ethertype = $urandom_range(1) ? pftm_pkg::ETH_IPV4 : pftm_pkg::ETH_IPV6;
            end
            if (acl_count != 0 && $urandom_range(3) != 0)
            begin
                e = acl_table[AW'($urandom_range(acl_count - 1))];
                if (e.src != '0) {h.src_hi, h.src_lo} = e.src;
                if (e.dst != '0) {h.dst_hi, h.dst_lo} = e.dst;
                if (e.sport != '0) h.src_port = e.sport;
                if (e.dport != '0) h.dst_port = e.dport;
                if ($urandom_range(9) == 0) h.src_lo = h.src_lo ^ (64'd1 << $urandom_range(63));
                if ($urandom_range(9) == 0) h.dst_port = h.dst_port + 16'd1;
            end
        end
        return h;
    endfunction

    task automatic present(input hdr_t h);
        req_if.action        <= h.action;
        req_if.ethertype     <= h.ethertype;
        req_if.next_proto    <= h.next_proto;
        req_if.src_addr_hi   <= h.src_hi;
        req_if.src_addr_lo   <= h.src_lo;
        req_if.dst_addr_hi   <= h.dst_hi;
        req_if.dst_addr_lo   <= h.dst_lo;
        req_if.src_port      <= h.src_port;
        req_if.dst_port      <= h.dst_port;
        req_if.rule_version  <= h.rule_version;
        req_if.rule_protocol <= h.rule_protocol;
    endtask

    task automatic deliver(input hdr_t h, input logic typed, input verdict_t want);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            req_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        present(h);
        req_if.valid <= 1'b1;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        account(h, typed, want);
    endtask

    task automatic flag_mismatch(input string msg);
        n_errors++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #800000;
        $display("tb_packet_five_tuple_rule_match_top failed");
        $finish;
    end

    // The sink holds off for a long stretch on entering the back-pressure phase.
    initial
    begin
        flow_phase_t seen;
        seen = PH_STEADY;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (flow == PH_BACKPRESSURE && seen != PH_BACKPRESSURE)
            begin
                seen = flow;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                seen = flow;
                rsp_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            n_results++;
            if (pending_verdicts.size() == 0)
            begin
                flag_mismatch($sformatf("result %0d arrived with nothing pending", n_results));
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (rsp_if.packet_class !== want.cls)
                    flag_mismatch($sformatf("result %0d packet_class %0d, expected %0d",
                                            n_results, rsp_if.packet_class, want.cls));
                if (rsp_if.matched !== want.matched)
                    flag_mismatch($sformatf("result %0d matched %0d, expected %0d",
                                            n_results, rsp_if.matched, want.matched));
                if (rsp_if.rule_hit !== want.hit)
                    flag_mismatch($sformatf("result %0d rule_hit %0d, expected %0d",
                                            n_results, rsp_if.rule_hit, want.hit));
            end
        end
    end

    initial
    begin
        acl_count = 0;
        flow      = PH_STEADY;
        idle_pct  = 0;
        stall_pct = 0;
        present('0);
        req_if.valid <= 1'b0;

        steps = '{
            row(8'd1, hdr(pftm_pkg::ACT_CLASSIFY, pftm_pkg::ETH_ARP, 8'h00, '0, '0, '0, '0,
                          '0, '0, pftm_pkg::VER_ANY, pftm_pkg::PR_ANY),
                1'b1, '{pftm_pkg::CLS_ARP, 1'b0, 4'd0}),
            row(8'd1, hdr(pftm_pkg::ACT_CLASSIFY, 16'hffff, 8'hff, ONES, ONES, ONES, ONES,
                          16'hffff, 16'hffff, VER_RSVD, PR_RSVD),
                1'b1, '{pftm_pkg::CLS_OTHER, 1'b0, 4'd0}),
            row(8'd1, hdr(pftm_pkg::ACT_CLASSIFY, pftm_pkg::ETH_IPV6, pftm_pkg::NP_ICMP4,
                          '0, '0, '0, '0, '0, '0, pftm_pkg::VER_ANY, pftm_pkg::PR_ANY),
                1'b1, '{pftm_pkg::CLS_OTHER, 1'b0, 4'd0}),
            row(8'd1, hdr(ACT_IGNORED, 16'hffff, 8'hff, ONES, ONES, ONES, ONES,
                          16'hffff, 16'hffff, VER_RSVD, PR_RSVD), 1'b0, NO_VERDICT),
            row(8'd1, hdr(pftm_pkg::ACT_APPEND, 16'h0, 8'h0, '0, '0, '0, '0, '0, '0,
                          pftm_pkg::VER_ANY, pftm_pkg::PR_ANY), 1'b0, NO_VERDICT),
            row(8'd1, hdr(pftm_pkg::ACT_CLASSIFY, pftm_pkg::ETH_IPV4, pftm_pkg::NP_UDP,
                          '0, V4_SRC, '0, V4_DST, 16'd53, 16'd53,
                          pftm_pkg::VER_ANY, pftm_pkg::PR_ANY),
                1'b1, '{pftm_pkg::CLS_UDP4, 1'b1, 4'd0}),
            row(8'd1, hdr(pftm_pkg::ACT_CLEAR, 16'hffff, 8'hff, ONES, ONES, ONES, ONES,
                          16'hffff, 16'hffff, VER_RSVD, PR_RSVD), 1'b0, NO_VERDICT),
            row(8'd1, hdr(pftm_pkg::ACT_APPEND, 16'h0, 8'h0, '0, V4_SRC, '0, V4_DST,
                          16'd1234, 16'd80, pftm_pkg::VER_V4, pftm_pkg::PR_TCP),
                1'b0, NO_VERDICT),
            row(8'd1, hdr(pftm_pkg::ACT_APPEND, 16'h0, 8'h0, ONES, ONES, ONES, ONES,
                          16'hffff, 16'hffff, pftm_pkg::VER_V6, pftm_pkg::PR_UDP),
                1'b0, NO_VERDICT),
            row(8'd1, hdr(pftm_pkg::ACT_APPEND, 16'h0, 8'h0, '0, '0, '0, '0, '0, '0,
                          VER_RSVD, pftm_pkg::PR_ANY), 1'b0, NO_VERDICT),
            row(8'd1, hdr(pftm_pkg::ACT_APPEND, 16'h0, 8'h0, '0, '0, '0, '0, '0, '0,
                          pftm_pkg::VER_ANY, PR_RSVD), 1'b0, NO_VERDICT),
            row(8'd11, hdr(pftm_pkg::ACT_APPEND, 16'h0, 8'h0, V6_HI, V6_LO, '0, '0, '0, '0,
                           pftm_pkg::VER_V6, pftm_pkg::PR_ICMP), 1'b0, NO_VERDICT),
            row(8'd1, hdr(pftm_pkg::ACT_APPEND, 16'h0, 8'h0, '0, '0, '0, '0, '0, '0,
                          pftm_pkg::VER_ANY, pftm_pkg::PR_ANY), 1'b0, NO_VERDICT),
            row(8'd2, hdr(pftm_pkg::ACT_APPEND, 16'h0, 8'h0, '0, '0, '0, '0, '0, '0,
                          pftm_pkg::VER_ANY, pftm_pkg::PR_UDP), 1'b0, NO_VERDICT),
            row(8'd1, hdr(pftm_pkg::ACT_CLASSIFY, pftm_pkg::ETH_IPV4, pftm_pkg::NP_TCP,
                          '0, V4_SRC, '0, V4_DST, 16'd1234, 16'd80,
                          pftm_pkg::VER_ANY, pftm_pkg::PR_ANY), 1'b0, NO_VERDICT),
            row(8'd1, hdr(pftm_pkg::ACT_CLASSIFY, pftm_pkg::ETH_IPV6, pftm_pkg::NP_TCP,
                          64'd1, 64'd2, 64'd3, 64'd4, 16'd1234, 16'd80,
                          pftm_pkg::VER_ANY, pftm_pkg::PR_ANY), 1'b0, NO_VERDICT),
            row(8'd1, hdr(pftm_pkg::ACT_CLASSIFY, pftm_pkg::ETH_IPV6, pftm_pkg::NP_UDP,
                          ONES, ONES, ONES, ONES, 16'hffff, 16'hffff,
                          pftm_pkg::VER_ANY, pftm_pkg::PR_ANY), 1'b0, NO_VERDICT),
            row(8'd1, hdr(pftm_pkg::ACT_CLASSIFY, pftm_pkg::ETH_ARP, 8'h00,
                          '0, V4_SRC, '0, V4_DST, '0, '0,
                          pftm_pkg::VER_ANY, pftm_pkg::PR_ANY), 1'b0, NO_VERDICT),
            row(8'd1, hdr(pftm_pkg::ACT_CLASSIFY, pftm_pkg::ETH_IPV6, pftm_pkg::NP_ICMP6,
                          V6_HI, V6_LO, 64'd7, 64'd8, '0, '0,
                          pftm_pkg::VER_ANY, pftm_pkg::PR_ANY), 1'b0, NO_VERDICT),
            row(8'd1, hdr(pftm_pkg::ACT_CLASSIFY, pftm_pkg::ETH_IPV4, pftm_pkg::NP_ICMP4,
                          '0, V4_SRC, '0, V4_DST, '0, '0,
                          pftm_pkg::VER_ANY, pftm_pkg::PR_ANY),
                1'b1, '{pftm_pkg::CLS_ICMP4, 1'b1, 4'd15})
        };

        wait (rst_n === 1'b1);
        @(posedge clk);

        foreach (steps[r])
        begin
            for (int unsigned k = 0; k < steps[r].reps; k++)
                deliver(steps[r].item, steps[r].typed, steps[r].want);
        end

        for (int p = PH_STEADY; p <= PH_BACKPRESSURE; p++)
        begin
            flow = flow_phase_t'(p);
            case (flow)
                PH_SRC_IDLE:
                begin
                    idle_pct  = 64;
                    stall_pct = 0;
                end
                PH_SNK_STALL:
                begin
                    idle_pct  = 0;
                    stall_pct = 64;
                end
                PH_BOTH_IDLE:
                begin
                    idle_pct  = 29;
                    stall_pct = 29;
                end
                default:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
            endcase
            for (int unsigned k = 0; k < ITEMS_PER_PHASE; k++)
                deliver(random_header(), 1'b0, NO_VERDICT);
        end

        req_if.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transfers: %0d classified, %0d matched, %0d on the last table slot",
                 n_transfers, n_classified, n_matched, n_top_hit);
        $display("%0d rules stored, %0d dropped on a full table, %0d clears, %0d ignored actions",
                 n_stored, n_dropped, n_clears, n_ignored);
        if (n_errors == 0)
        begin
            $display("tb_packet_five_tuple_rule_match_top passed");
        end
        else
        begin
            $display("tb_packet_five_tuple_rule_match_top failed");
        end
        $finish;
    end

endmodule
